/* hw/rtl/fwrv_pkg.sv */
package fwrv_pkg;

    localparam int MAX_FIELDS = 32;
    localparam int CNT_W      = 6;
    localparam int COL_W      = 10;
    localparam int LEN_W      = 11;
    localparam int LINE_W     = 32;
    localparam int WORD_LEN   = 10;
    localparam int TITLE_LEN  = 13;

    localparam logic [3:0] OFS_DOT  = 4'd1;
    localparam logic [3:0] OFS_LAST = 4'd9;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TITLE     = 3'd1,
        ST_BLANK     = 3'd2,
        ST_LENGTH    = 3'd3,
        ST_SYMBOL    = 3'd4,
        ST_DIGIT     = 3'd5,
        ST_IN_COUNT  = 3'd6,
        ST_SEPARATOR = 3'd7
    } status_t;

    typedef enum logic [2:0] {
        PH_TITLE = 3'b001,
        PH_BLANK = 3'b010,
        PH_DATA  = 3'b100
    } phase_t;

    typedef struct packed {
        logic       req_type;
        logic [7:0] data_byte;
    } in_beat_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [LINE_W-1:0] line_number;
        logic [COL_W-1:0]  position;
    } out_beat_t;

    typedef struct packed {
        logic       valid;
        logic       eof;
        logic [7:0] data;
    } step_t;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic             title_ok;
        logic             len_ok;
        logic [2:0]       err_kind;
        logic [COL_W-1:0] err_pos;
    } line_sum_t;

    function automatic logic [7:0] title_char(input logic [3:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0:    ch = 8'h54;
            4'd1:    ch = 8'h52;
            4'd2:    ch = 8'h41;
            4'd3:    ch = 8'h49;
            4'd4:    ch = 8'h4E;
            4'd5:    ch = 8'h49;
            4'd6:    ch = 8'h4E;
            4'd7:    ch = 8'h47;
            4'd8:    ch = 8'h20;
            4'd9:    ch = 8'h44;
            4'd10:   ch = 8'h41;
            4'd11:   ch = 8'h54;
            4'd12:   ch = 8'h41;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

endpackage

/* hw/rtl/fwrv_line_check.sv */
module fwrv_line_check (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  fwrv_pkg::step_t                      step,
    input  fwrv_pkg::phase_t                     phase,
    input  logic                                 active,
    input  logic [fwrv_pkg::CNT_W-1:0]           num_inputs,
    input  logic [fwrv_pkg::CNT_W-1:0]           num_outputs,
    output fwrv_pkg::line_sum_t                  sum
);

    localparam int COL_W = fwrv_pkg::COL_W;
    localparam int LEN_W = fwrv_pkg::LEN_W;
    localparam int CNT_W = fwrv_pkg::CNT_W;

    logic [COL_W-1:0] col_reg, col_next;
    logic [3:0]       ofs_reg, ofs_next;
    logic [COL_W-1:0] wstart_reg, wstart_next;
    logic             title_ok_reg, title_ok_next;
    logic [1:0]       flags_reg, flags_next;
    logic [2:0]       kind_reg, kind_next;
    logic [COL_W-1:0] pos_reg, pos_next;

    logic [CNT_W-1:0] ni, no;
    logic [LEN_W-1:0] in_end, line_len, col_x;
    logic             is_lf, line_end, byte_in, slash_ok;
    logic [1:0]       wf;

    always_comb begin
        ni = (num_inputs > CNT_W'(fwrv_pkg::MAX_FIELDS)) ?
             CNT_W'(fwrv_pkg::MAX_FIELDS) : num_inputs;
        no = (num_outputs > CNT_W'(fwrv_pkg::MAX_FIELDS)) ?
             CNT_W'(fwrv_pkg::MAX_FIELDS) : num_outputs;
        in_end   = LEN_W'(ni) * LEN_W'(fwrv_pkg::WORD_LEN);
        line_len = in_end + LEN_W'(no) * LEN_W'(fwrv_pkg::WORD_LEN) + LEN_W'(1);
        col_x    = {1'b0, col_reg};
        is_lf    = step.data == fwrv_pkg::CH_LF;
        line_end = step.valid && (step.eof || is_lf);
        byte_in  = step.valid && !step.eof && !is_lf;
        slash_ok = col_x < in_end;
        wf       = 2'b00;

        col_next      = col_reg;
        ofs_next      = ofs_reg;
        wstart_next   = wstart_reg;
        title_ok_next = title_ok_reg;
        flags_next    = flags_reg;
        kind_next     = kind_reg;
        pos_next      = pos_reg;

        if (line_end) begin
            col_next      = '0;
            ofs_next      = '0;
            wstart_next   = '0;
            title_ok_next = 1'b1;
            flags_next    = '0;
            kind_next     = fwrv_pkg::ST_OK;
            pos_next      = '0;
        end else if (byte_in) begin
            col_next = (col_reg == '1) ? col_reg : col_reg + COL_W'(1);

            // word offset tracking; separator columns sit between the groups
            if (col_x == in_end) begin
                ofs_next = ofs_reg;
            end else if (col_x == in_end + LEN_W'(1)) begin
                ofs_next    = '0;
                wstart_next = col_reg + COL_W'(1);
            end else if (ofs_reg == fwrv_pkg::OFS_LAST) begin
                ofs_next    = '0;
                wstart_next = col_reg + COL_W'(1);
            end else begin
                ofs_next = ofs_reg + 4'd1;
            end

            if (active && phase == fwrv_pkg::PH_TITLE) begin
                if (col_x >= LEN_W'(fwrv_pkg::TITLE_LEN) ||
                    step.data != fwrv_pkg::title_char(col_reg[3:0])) begin
                    title_ok_next = 1'b0;
                end
            end

            if (active && phase == fwrv_pkg::PH_DATA &&
                kind_reg == fwrv_pkg::ST_OK && col_x < line_len) begin
                if (col_x == in_end) begin
                    if (step.data != fwrv_pkg::CH_SLASH) kind_next = fwrv_pkg::ST_SEPARATOR;
                end else if (col_x == in_end + LEN_W'(1)) begin
                    if (step.data != fwrv_pkg::CH_SPACE) kind_next = fwrv_pkg::ST_SEPARATOR;
                end else if (ofs_reg == '0 && slash_ok && step.data == fwrv_pkg::CH_SLASH) begin
                    kind_next = fwrv_pkg::ST_IN_COUNT;
                    pos_next  = '0;
                end else if (ofs_reg == fwrv_pkg::OFS_DOT) begin
                    if (step.data != fwrv_pkg::CH_DOT) flags_next[0] = 1'b1;
                end else if (ofs_reg == fwrv_pkg::OFS_LAST) begin
                    wf = flags_reg | {1'b0, step.data != fwrv_pkg::CH_SPACE};
                    if (wf[0]) begin
                        kind_next = fwrv_pkg::ST_SYMBOL;
                        pos_next  = wstart_reg + COL_W'(1);
                    end else if (wf[1]) begin
                        kind_next = fwrv_pkg::ST_DIGIT;
                        pos_next  = wstart_reg + COL_W'(1);
                    end
                    flags_next = '0;
                end else if (!fwrv_pkg::is_digit(step.data)) begin
                    flags_next[1] = 1'b1;
                end
            end
        end
    end

    // line summary, with the last word judged by the implied trailing space
    always_comb begin
        sum.col      = col_reg;
        sum.title_ok = title_ok_reg;
        sum.len_ok   = col_x == line_len;
        sum.err_kind = kind_reg;
        sum.err_pos  = pos_reg;
        if (sum.len_ok && kind_reg == fwrv_pkg::ST_OK && no != '0) begin
            if (flags_reg[0]) begin
                sum.err_kind = fwrv_pkg::ST_SYMBOL;
                sum.err_pos  = wstart_reg + COL_W'(1);
            end else if (flags_reg[1]) begin
                sum.err_kind = fwrv_pkg::ST_DIGIT;
                sum.err_pos  = wstart_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            ofs_reg      <= '0;
            wstart_reg   <= '0;
            title_ok_reg <= 1'b1;
            flags_reg    <= '0;
            kind_reg     <= fwrv_pkg::ST_OK;
            pos_reg      <= '0;
        end else begin
            col_reg      <= col_next;
            ofs_reg      <= ofs_next;
            wstart_reg   <= wstart_next;
            title_ok_reg <= title_ok_next;
            flags_reg    <= flags_next;
            kind_reg     <= kind_next;
            pos_reg      <= pos_next;
        end
    end

endmodule

/* hw/rtl/fwrv_file_status.sv */
module fwrv_file_status (
    input  logic                aclk,
    input  logic                aresetn,
    input  fwrv_pkg::step_t     step,
    input  fwrv_pkg::line_sum_t sum,
    output fwrv_pkg::phase_t    phase,
    output logic                active,
    output fwrv_pkg::out_beat_t result
);

    localparam int COL_W  = fwrv_pkg::COL_W;
    localparam int LINE_W = fwrv_pkg::LINE_W;

    fwrv_pkg::phase_t  phase_reg, phase_next, phase_fin;
    logic [LINE_W-1:0] cnt_reg, cnt_next, cnt_fin, lineno;
    logic [2:0]        st_reg, st_next, st_fin;
    logic [LINE_W-1:0] ln_reg, ln_next, ln_fin;
    logic [COL_W-1:0]  pos_reg, pos_next, pos_fin;
    logic              fin;

    always_comb begin
        fin = step.valid && ((!step.eof && step.data == fwrv_pkg::CH_LF) ||
                             (step.eof && sum.col != '0));
        lineno = (cnt_reg == '1) ? cnt_reg : cnt_reg + LINE_W'(1);

        st_fin    = st_reg;
        ln_fin    = ln_reg;
        pos_fin   = pos_reg;
        cnt_fin   = cnt_reg;
        phase_fin = phase_reg;

        if (fin) begin
            if (st_reg == fwrv_pkg::ST_OK) begin
                case (phase_reg)
                    fwrv_pkg::PH_TITLE: begin
                        if (!(sum.title_ok && sum.col == COL_W'(fwrv_pkg::TITLE_LEN))) begin
                            st_fin = fwrv_pkg::ST_TITLE;
                            ln_fin = lineno;
                        end
                    end
                    fwrv_pkg::PH_BLANK: begin
                        if (sum.col != '0) begin
                            st_fin = fwrv_pkg::ST_BLANK;
                            ln_fin = lineno;
                        end
                    end
                    fwrv_pkg::PH_DATA: begin
                        if (!sum.len_ok) begin
                            st_fin = fwrv_pkg::ST_LENGTH;
                            ln_fin = lineno;
                        end else if (sum.err_kind != fwrv_pkg::ST_OK) begin
                            st_fin  = sum.err_kind;
                            ln_fin  = lineno;
                            pos_fin = sum.err_pos;
                        end
                    end
                    default: st_fin = st_reg;
                endcase
            end
            cnt_fin = lineno;
            case (phase_reg)
                fwrv_pkg::PH_TITLE: phase_fin = fwrv_pkg::PH_BLANK;
                default:            phase_fin = fwrv_pkg::PH_DATA;
            endcase
        end

        result.status      = st_fin;
        result.line_number = ln_fin;
        result.position    = pos_fin;
        if (st_fin == fwrv_pkg::ST_OK) begin
            if (cnt_fin == '0) begin
                result.status      = fwrv_pkg::ST_TITLE;
                result.line_number = LINE_W'(1);
                result.position    = '0;
            end else if (cnt_fin == LINE_W'(1)) begin
                result.status      = fwrv_pkg::ST_BLANK;
                result.line_number = LINE_W'(2);
                result.position    = '0;
            end
        end

        if (step.valid && step.eof) begin
            phase_next = fwrv_pkg::PH_TITLE;
            cnt_next   = '0;
            st_next    = fwrv_pkg::ST_OK;
            ln_next    = '0;
            pos_next   = '0;
        end else begin
            phase_next = phase_fin;
            cnt_next   = cnt_fin;
            st_next    = st_fin;
            ln_next    = ln_fin;
            pos_next   = pos_fin;
        end
    end

    assign phase  = phase_reg;
    assign active = st_reg == fwrv_pkg::ST_OK;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= fwrv_pkg::PH_TITLE;
            cnt_reg   <= '0;
            st_reg    <= fwrv_pkg::ST_OK;
            ln_reg    <= '0;
            pos_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            st_reg    <= st_next;
            ln_reg    <= ln_next;
            pos_reg   <= pos_next;
        end
    end

endmodule

/* hw/rtl/fixed_width_record_validator.sv */
// Streaming checker for a training-data text file.
// s_ channel: one beat per file byte (req_type 0) or an end-of-file beat
// (req_type 1). A 0x0A byte closes a line. Only the end-of-file beat yields
// a result on the m_ channel: status, line of the first error and the
// start column of the faulty word.
// APB port: num_inputs at 0x0, num_outputs at 0x4 (6 bits each, reset 1);
// write them only while no beat is in flight.
// Throughput: one beat per cycle, data and end of file alike, but for the
// stall below. A beat passes through the input register; the result of an
// end-of-file beat is then registered and shows on m_valid.
// Stall: while a result waits for m_ready, byte beats still flow; a second
// end-of-file beat waits in the input register, and s_ready drops only then.
// Reset: registers return to 1, all line and error state clears, no result.
// After each end-of-file beat the checker starts over from the title line.
module fixed_width_record_validator (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  fwrv_pkg::in_beat_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output fwrv_pkg::out_beat_t m_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int CNT_W = fwrv_pkg::CNT_W;

    logic [CNT_W-1:0]    num_inputs_reg, num_inputs_next;
    logic [CNT_W-1:0]    num_outputs_reg, num_outputs_next;
    logic                in_valid_reg, in_valid_next;
    fwrv_pkg::in_beat_t  in_beat_reg, in_beat_next;
    logic                m_valid_reg, m_valid_next;
    fwrv_pkg::out_beat_t m_data_reg, m_data_next;

    logic                advance, cfg_wr;
    fwrv_pkg::step_t     step;
    fwrv_pkg::phase_t    phase;
    logic                active;
    fwrv_pkg::line_sum_t sum;
    fwrv_pkg::out_beat_t result;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign prdata  = paddr[2] ? {{(32-CNT_W){1'b0}}, num_outputs_reg}
                              : {{(32-CNT_W){1'b0}}, num_inputs_reg};

    assign advance = !in_beat_reg.req_type || !m_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;

    assign step.valid = in_valid_reg && advance;
    assign step.eof   = in_beat_reg.req_type;
    assign step.data  = in_beat_reg.data_byte;

    fwrv_line_check u_line (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step),
        .phase       (phase),
        .active      (active),
        .num_inputs  (num_inputs_reg),
        .num_outputs (num_outputs_reg),
        .sum         (sum)
    );

    fwrv_file_status u_status (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .sum     (sum),
        .phase   (phase),
        .active  (active),
        .result  (result)
    );

    always_comb begin
        num_inputs_next  = num_inputs_reg;
        num_outputs_next = num_outputs_reg;
        if (cfg_wr) begin
            if (paddr[2]) num_outputs_next = pwdata[CNT_W-1:0];
            else          num_inputs_next  = pwdata[CNT_W-1:0];
        end

        in_valid_next = in_valid_reg;
        in_beat_next  = in_beat_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
            in_beat_next  = s_data;
        end else if (step.valid) begin
            in_valid_next = 1'b0;
        end

        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (step.valid && step.eof) begin
            m_valid_next = 1'b1;
            m_data_next  = result;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_inputs_reg  <= CNT_W'(1);
            num_outputs_reg <= CNT_W'(1);
            in_valid_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            num_inputs_reg  <= num_inputs_next;
            num_outputs_reg <= num_outputs_next;
            in_valid_reg    <= in_valid_next;
            m_valid_reg     <= m_valid_next;
        end
        in_beat_reg <= in_beat_next;
        m_data_reg  <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_result_from_eof: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(in_valid_reg && in_beat_reg.req_type))
        else $error("result without end-of-file beat");

    a_ok_is_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.status == fwrv_pkg::ST_OK) |->
        (m_data_reg.line_number == '0 && m_data_reg.position == '0))
        else $error("success result carries line or position");

    a_pos_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.position != '0) |->
        (m_data_reg.status == fwrv_pkg::ST_SYMBOL ||
         m_data_reg.status == fwrv_pkg::ST_DIGIT))
        else $error("position set for a non-word error");

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_beat_reg)))
        else $error("stalled input beat lost");
`endif

endmodule

/* tb/sv/fixed_width_record_validator_checker.sv */
`timescale 1ns / 100ps

module fixed_width_record_validator_checker #(
    parameter logic [2:0] ADDR_NUM_INPUTS  = 3'd0,
    parameter logic [2:0] ADDR_NUM_OUTPUTS = 3'd4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  fwrv_pkg::in_beat_t  s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  fwrv_pkg::out_beat_t m_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    input  logic [31:0]         prdata,
    input  logic                pready,
    output int                  mismatches,
    output int                  awaiting
);
    import fwrv_pkg::*;

    localparam logic [8*TITLE_LEN-1:0] TITLE_TEXT = "TRAINING DATA";

    logic [5:0]  cfg_in_words;
    logic [5:0]  cfg_out_words;
    phase_t      phase;
    logic [9:0]  col;
    logic [31:0] lines_done;
    logic        title_ok;
    logic [1:0]  word_bad;      // [0] symbol, [1] digit
    status_t     line_err;
    logic [9:0]  line_err_col;
    status_t     held_status;
    logic [31:0] held_line;
    logic [9:0]  held_col;
    out_beat_t   file_verdicts[$];

    initial mismatches = 0;
    initial awaiting = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    function automatic int clamp_count(input logic [5:0] v);
        return (v > MAX_FIELDS) ? MAX_FIELDS : int'(v);
    endfunction

    function automatic void clear_file();
        phase = PH_TITLE;
        col = '0;
        lines_done = '0;
        title_ok = 1'b1;
        word_bad = '0;
        line_err = ST_OK;
        line_err_col = '0;
        held_status = ST_OK;
        held_line = '0;
        held_col = '0;
    endfunction

    function automatic void flag_line(input status_t kind, input int pos);
        if (line_err == ST_OK) begin
            line_err = kind;
            line_err_col = pos[9:0];
        end
    endfunction

    function automatic void close_word(input int start);
        if (word_bad[0])
            flag_line(ST_SYMBOL, start + 1);
        else if (word_bad[1])
            flag_line(ST_DIGIT, start + 1);
        word_bad = '0;
    endfunction

    function automatic void word_char(input int ofs, input int start, input logic [7:0] b,
                                      input bit slash_counts);
        if (ofs == 0 && slash_counts && b == CH_SLASH) begin
            flag_line(ST_IN_COUNT, 0);
        end else if (ofs == 1) begin
            if (b != CH_DOT)
                word_bad[0] = 1'b1;
        end else if (ofs == 9) begin
            if (b != CH_SPACE)
                word_bad[0] = 1'b1;
            close_word(start);
        end else if (!(b >= CH_ZERO && b <= CH_NINE)) begin
            word_bad[1] = 1'b1;
        end
    endfunction

    function automatic void data_char(input int c, input logic [7:0] b);
        int ni = clamp_count(cfg_in_words);
        int no = clamp_count(cfg_out_words);
        int in_end = 10 * ni;
        int len = 10 * (ni + no) + 1;
        int ofs;
        if (line_err != ST_OK || c >= len)
            return;
        if (c < in_end) begin
            ofs = c % 10;
            word_char(ofs, c - ofs, b, 1'b1);
        end else if (c == in_end) begin
            if (b != CH_SLASH)
                flag_line(ST_SEPARATOR, 0);
        end else if (c == in_end + 1) begin
            if (b != CH_SPACE)
                flag_line(ST_SEPARATOR, 0);
        end else begin
            ofs = (c - in_end - 2) % 10;
            word_char(ofs, c - ofs, b, 1'b0);
        end
    endfunction

    function automatic void latch_error(input status_t st, input logic [31:0] ln,
                                        input logic [9:0] pos);
        held_status = st;
        held_line = ln;
        held_col = pos;
    endfunction

    function automatic void end_line();
        logic [31:0] num = (lines_done == '1) ? lines_done : lines_done + 32'd1;
        int ni = clamp_count(cfg_in_words);
        int no = clamp_count(cfg_out_words);
        int len = 10 * (ni + no) + 1;
        if (held_status == ST_OK) begin
            if (phase == PH_TITLE) begin
                if (!(title_ok && col == TITLE_LEN))
                    latch_error(ST_TITLE, num, '0);
            end else if (phase == PH_BLANK) begin
                if (col != 0)
                    latch_error(ST_BLANK, num, '0);
            end else if (col != len) begin
                latch_error(ST_LENGTH, num, '0);
            end else begin
                // last output word has no trailing space to close it
                if (line_err == ST_OK && no > 0)
                    close_word(10 * ni + 2 + 10 * (no - 1));
                if (line_err != ST_OK)
                    latch_error(line_err, num, line_err_col);
            end
        end
        if (phase == PH_TITLE)
            phase = PH_BLANK;
        else if (phase == PH_BLANK)
            phase = PH_DATA;
        if (lines_done != '1)
            lines_done++;
        col = '0;
        title_ok = 1'b1;
        word_bad = '0;
        line_err = ST_OK;
        line_err_col = '0;
    endfunction

    function automatic void advance_file(input in_beat_t beat);
        out_beat_t verdict;
        int idx = col;
        if (!beat.req_type) begin
            if (beat.data_byte == CH_LF) begin
                end_line();
            end else begin
                if (held_status == ST_OK) begin
                    if (phase == PH_TITLE) begin
                        if (idx >= TITLE_LEN ||
                            beat.data_byte != TITLE_TEXT[8*(TITLE_LEN-1-idx) +: 8])
                            title_ok = 1'b0;
                    end else if (phase == PH_DATA) begin
                        data_char(idx, beat.data_byte);
                    end
                end
                if (col != 10'd1023)
                    col++;
            end
            return;
        end
        if (col > 0)
            end_line();
        if (held_status == ST_OK) begin
            if (lines_done < 1)
                latch_error(ST_TITLE, 32'd1, '0);
            else if (lines_done < 2)
                latch_error(ST_BLANK, 32'd2, '0);
        end
        verdict.status = held_status;
        verdict.line_number = held_line;
        verdict.position = held_col;
        file_verdicts.push_back(verdict);
        clear_file();
    endfunction

    always @(posedge aclk) begin
        out_beat_t want;
        if (!aresetn) begin
            cfg_in_words = 6'd1;
            cfg_out_words = 6'd1;
            clear_file();
            file_verdicts.delete();
        end else begin
            if (psel && penable && pready) begin
                if (pwrite) begin
                    if (paddr == ADDR_NUM_INPUTS)
                        cfg_in_words = pwdata[5:0];
                    else if (paddr == ADDR_NUM_OUTPUTS)
                        cfg_out_words = pwdata[5:0];
                end else if (paddr == ADDR_NUM_INPUTS) begin
                    if (prdata !== {26'd0, cfg_in_words})
                        report_mismatch("num_inputs readback", prdata, {26'd0, cfg_in_words});
                end else if (paddr == ADDR_NUM_OUTPUTS) begin
                    if (prdata !== {26'd0, cfg_out_words})
                        report_mismatch("num_outputs readback", prdata,
                                        {26'd0, cfg_out_words});
                end
            end
            if (s_valid && s_ready)
                advance_file(s_data);
            if (m_valid && m_ready) begin
                if (file_verdicts.size() == 0) begin
                    report_mismatch("result beat with none pending", m_data.line_number, '0);
                end else begin
                    want = file_verdicts.pop_front();
                    if (m_data.status !== want.status)
                        report_mismatch("status", m_data.status, want.status);
                    if (m_data.line_number !== want.line_number)
                        report_mismatch("line_number", m_data.line_number, want.line_number);
                    if (m_data.position !== want.position)
                        report_mismatch("position", m_data.position, want.position);
                end
            end
        end
        awaiting <= file_verdicts.size();
    end

endmodule

/* tb/sv/fixed_width_record_validator_test.sv */
`timescale 1ns / 100ps

module fixed_width_record_validator_test;
    import fwrv_pkg::*;

    localparam logic [2:0] ADDR_NUM_INPUTS  = 3'd0;
    localparam logic [2:0] ADDR_NUM_OUTPUTS = 3'd4;
    localparam logic [5:0] CORNER_IN[6]  = '{6'd0, 6'd63, 6'd32, 6'd0, 6'd7, 6'd33};
    localparam logic [5:0] CORNER_OUT[6] = '{6'd0, 6'd63, 6'd32, 6'd5, 6'd0, 6'd1};

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_beat_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_beat_t   m_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int          mismatches;
    int          awaiting;
    int          hold_off = 0;
    int          burst_left = 0;
    int          files_sent = 0;
    int          beats_sent = 0;
    int          settings_used = 0;
    logic [5:0]  cur_in = 6'd1;
    logic [5:0]  cur_out = 6'd1;
    logic [7:0]  file_text[$];

    fixed_width_record_validator dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    fixed_width_record_validator_checker #(
        .ADDR_NUM_INPUTS  (ADDR_NUM_INPUTS),
        .ADDR_NUM_OUTPUTS (ADDR_NUM_OUTPUTS)
    ) checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .mismatches (mismatches),
        .awaiting   (awaiting)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("fixed_width_record_validator test failed");
        $finish;
    end

    // result side: stall pattern is redrawn at random intervals
    initial begin
        int mode;
        forever begin
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(20, 150)) begin
                @(posedge aclk);
                if (hold_off > 0) begin
                    m_ready <= 1'b0;
                    repeat (hold_off) @(posedge aclk);
                    hold_off = 0;
                end
                case (mode)
                    1:       m_ready <= $urandom_range(0, 1);
                    2:       m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= 1'b1;
                endcase
            end
        end
    end

    function automatic int clamp_count(input logic [5:0] v);
        return (v > MAX_FIELDS) ? MAX_FIELDS : int'(v);
    endfunction

    function automatic void put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            file_text.push_back(s[i]);
    endfunction

    function automatic void put_word();
        file_text.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
        file_text.push_back(CH_DOT);
        repeat (7) file_text.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
        file_text.push_back(CH_SPACE);
    endfunction

    function automatic void put_record_line();
        repeat (clamp_count(cur_in)) put_word();
        put_text("/ ");
        repeat (clamp_count(cur_out)) put_word();
        file_text[file_text.size() - 1] = CH_LF;
    endfunction

    function automatic logic [7:0] junk_byte();
        case ($urandom_range(0, 6))
            0:       return CH_SLASH;
            1:       return CH_DOT;
            2:       return CH_SPACE;
            3:       return 8'($urandom_range(CH_ZERO, CH_NINE));
            4:       return CH_LF;
            5:       return "A";
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic void damage_file();
        int kind = $urandom_range(0, 9);
        int n = file_text.size();
        if (n == 0 || kind < 4)
            return;
        case (kind)
            4, 5: file_text[$urandom_range(0, n - 1)] = junk_byte();
            6:    file_text.delete($urandom_range(0, n - 1));
            7:    file_text.insert($urandom_range(0, n), junk_byte());
            8: begin
                if (file_text[n - 1] == CH_LF)
                    file_text.delete(n - 1);
            end
            default: repeat (3) file_text[$urandom_range(0, n - 1)] = junk_byte();
        endcase
    endfunction

    function automatic void build_random_file();
        int lines;
        file_text.delete();
        if ($urandom_range(0, 11) == 0) begin
            repeat ($urandom_range(0, 40))
                file_text.push_back(($urandom_range(0, 7) == 0) ? CH_LF : 8'($urandom));
            return;
        end
        put_text("TRAINING DATA\n\n");
        lines = (clamp_count(cur_in) + clamp_count(cur_out) > 12) ? 1 : $urandom_range(0, 3);
        repeat (lines) put_record_line();
        damage_file();
    endfunction

    function automatic logic [5:0] pick_count();
        int r = $urandom_range(0, 9);
        if (r < 7)
            return 6'($urandom_range(0, 4));
        else if (r < 9)
            return 6'($urandom_range(5, 12));
        return 6'($urandom_range(13, 63));
    endfunction

    task automatic send_beat(input in_beat_t beat);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 300)
                                                      : $urandom_range(1, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data <= beat;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_file();
        in_beat_t beat;
        foreach (file_text[i]) begin
            beat.req_type = 1'b0;
            beat.data_byte = file_text[i];
            send_beat(beat);
        end
        beat.req_type = 1'b1;
        beat.data_byte = 8'($urandom);
        send_beat(beat);
        files_sent++;
        beats_sent += file_text.size() + 1;
    endtask

    task automatic send_text(input string s);
        file_text.delete();
        put_text(s);
        send_file();
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (awaiting != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= addr;
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
    endtask

    task automatic set_fields(input logic [5:0] ni, input logic [5:0] no);
        apb_access(1'b1, ADDR_NUM_INPUTS, {26'($urandom), ni});
        apb_access(1'b1, ADDR_NUM_OUTPUTS, {26'($urandom), no});
        apb_access(1'b0, ADDR_NUM_INPUTS, '0);
        apb_access(1'b0, ADDR_NUM_OUTPUTS, '0);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
        cur_in = ni;
        cur_out = no;
        settings_used++;
    endtask

    initial begin
        int phase_no = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset setting: one input word, one output word
        send_text("");
        send_text("TRAINING DATA\n");
        send_text("TRAINING DATA\n\n");
        send_text("TRAINING DATA\n\n1.2345678 / 9.8765432\n0.0000000 / 9.9999999\n");
        send_text("TRAINING DATA\n\n1.2345678 / 9.8765432");
        send_text("TRAINING DATa\n\n");
        send_text("TRAINING DATAX\n\n");
        send_text("TRAINING DATA\nx\n");
        send_text("TRAINING DATA\n\n1.2345678 / 9.876543\n");
        send_text("TRAINING DATA\n\n/.2345678 / 9.8765432\n");
        send_text("TRAINING DATA\n\n1,2345678 / 9.8765432\n");
        send_text("TRAINING DATA\n\n1.23x5678 / 9.8765432\n");
        send_text("TRAINING DATA\n\n1.2x45678,/ 9.8765432\n");
        send_text("TRAINING DATA\n\n1.2345678 |x9.8765432\n");
        send_text("TRAINING DATA\n\n1.2345678 / 9.87654x2\n");
        send_text("TRAINING DATA\n\n1.2345678 / /.8765432\n");
        send_text("TRAINING DATA\n\n1.2345678 / 9.8765432\n1.2345678 / 9.8765432 \nzz\n");
        file_text.delete();
        put_text("TRAINING DATA\n\n");
        repeat (1100) file_text.push_back("1");
        file_text.push_back(CH_LF);
        send_file();
        file_text.delete();
        put_text("TRAINING DATA\n\n1.2345678 / 9.876543");
        file_text.push_back(8'h00);
        file_text.push_back(CH_LF);
        file_text.push_back(8'hFF);
        send_file();

        while (files_sent < 60 || beats_sent < 1000) begin
            drain();
            if (phase_no < 6)
                set_fields(CORNER_IN[phase_no], CORNER_OUT[phase_no]);
            else
                set_fields(pick_count(), pick_count());
            if (phase_no == 3) begin
                // results back up while short files keep coming
                hold_off = 400;
                repeat (5) send_text("TRAINING DATA\n\n");
            end
            repeat ($urandom_range(3, 8)) begin
                build_random_file();
                send_file();
            end
            phase_no++;
        end
        drain();

        $display("Checked %0d files over %0d input beats with %0d register settings.",
                 files_sent, beats_sent, settings_used);
        $display("Word counts ran from zero to 63 per side, with clean and damaged files.");
        if (mismatches == 0)
            $display("fixed_width_record_validator test passed");
        else
            $display("fixed_width_record_validator test failed");
        $finish;
    end

endmodule
